// ----- rtl/skr_pkg.sv -----
// Package for the sorted key registry: action and result codes, and the
// request and response transaction types. No dependencies.
`default_nettype none
package skr_pkg;

	localparam logic [2:0] ACT_REGISTER = 3'd0;
	localparam logic [2:0] ACT_ADD_EQUIP = 3'd1;
	localparam logic [2:0] ACT_ADD_DEPEND = 3'd2;
	localparam logic [2:0] ACT_SET_REFS = 3'd3;
	localparam logic [2:0] ACT_SET_STATUS = 3'd4;
	localparam logic [2:0] ACT_LOOKUP = 3'd5;

	localparam logic [2:0] RC_OK = 3'd0;
	localparam logic [2:0] RC_FULL = 3'd1;
	localparam logic [2:0] RC_DUP = 3'd2;
	localparam logic [2:0] RC_BADARG = 3'd3;
	localparam logic [2:0] RC_NOTFOUND = 3'd4;
	localparam logic [2:0] RC_LISTFULL = 3'd5;

	typedef struct packed {
		logic [2:0]  action;
		logic [63:0] entry_key;
		logic [63:0] owner_ref;
		logic [31:0] scope_code;
		logic [63:0] cohort_id;
		logic [63:0] origin_ref;
		logic [63:0] item_key;
		logic [31:0] item_qty;
		logic [63:0] readiness_id;
		logic [63:0] morale_id;
		logic [31:0] status_word;
	} req_t;

	typedef struct packed {
		logic [2:0]  result_code;
		logic [63:0] entry_id;
		logic [63:0] entry_owner;
		logic [31:0] entry_scope;
		logic [63:0] entry_cohort;
		logic [63:0] entry_origin;
		logic [63:0] entry_readiness;
		logic [63:0] entry_morale;
		logic [31:0] entry_status;
		logic [3:0]  equip_count;
		logic [3:0]  depend_count;
	} rsp_t;

endpackage
`default_nettype wire

// ----- rtl/skr_ram.sv -----
// Simple dual-port memory: one write port, one read port with registered data.
// Used for all row and list storage of the registry. No dependencies.
`default_nettype none
module skr_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 64,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ----- rtl/sorted_key_registry_with_sublists.sv -----
// Top level of the sorted key registry with per-entry sublists.
// Depends on skr_pkg and skr_ram.
//
// Usage: a request transaction (req, req_valid, req_stall) carries one action;
// each request yields exactly one response transaction (rsp, rsp_valid,
// rsp_stall). req_stall is high while a request is in work, so one request is
// processed at a time. The configuration channel (cfg_valid, cfg_ready,
// cfg_data) loads the automatic key counter; a written zero loads one.
// Operation: a sequencer drives one compare unit over the memories. The table
// search reads and compares one row at a time (S_SRD, S_SCMP); an insert
// shifts rows one at a time (S_TSHRD, S_TSHWR). List search and list shift
// step through the slots the same way. The next request is accepted in the
// cycle after the response is loaded.
// Reset clears the row count, loads the counter with one and empties the
// response register; row storage needs no clearing. A response waits in its
// register while rsp_stall is high; the sequencer holds in S_DONE until it is taken.
`default_nettype none
module sorted_key_registry_with_sublists
	import skr_pkg::*;
#(
	parameter int TABLE_DEPTH = 64,
	parameter int EQUIP_SLOTS = 8,
	parameter int DEPEND_SLOTS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire req_t        req,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output rsp_t             rsp,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [63:0] cfg_data
);

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int ECW = $clog2(EQUIP_SLOTS + 1);
	localparam int DCW = $clog2(DEPEND_SLOTS + 1);
	localparam int LMAX = (EQUIP_SLOTS > DEPEND_SLOTS) ? EQUIP_SLOTS : DEPEND_SLOTS;
	localparam int LCW = $clog2(LMAX + 1);
	localparam int EDEPTH = TABLE_DEPTH * EQUIP_SLOTS;
	localparam int DDEPTH = TABLE_DEPTH * DEPEND_SLOTS;
	localparam int EAW = (EDEPTH > 1) ? $clog2(EDEPTH) : 1;
	localparam int DAW = (DDEPTH > 1) ? $clog2(DDEPTH) : 1;

	typedef struct packed {
		logic [63:0]    owner;
		logic [63:0]    cohort;
		logic [63:0]    origin;
		logic [63:0]    readiness;
		logic [63:0]    morale;
		logic [31:0]    scope;
		logic [31:0]    status;
		logic [ECW-1:0] eq_n;
		logic [DCW-1:0] dep_n;
	} row_t;

	typedef enum logic [4:0] {
		S_IDLE, S_START, S_SRD, S_SCMP, S_FOUND, S_TSHRD, S_TSHWR, S_TINS,
		S_ORD, S_ORDW, S_ROWR, S_ROWW, S_LRD, S_LCMP, S_LFND, S_LSHRD,
		S_LSHWR, S_LINS, S_WB, S_DONE
	} state_t;

	state_t          state_q;
	req_t            req_q;
	logic [63:0]     key_q;
	logic [63:0]     counter_q;
	logic [CW-1:0]   total_q;
	logic [CW-1:0]   idx_q;
	logic [CW-1:0]   at_q;
	logic [CW-1:0]   j_q;
	logic            hit_q;
	logic [IW-1:0]   slot_q;
	row_t            row_q;
	logic            have_row_q;
	logic [2:0]      rc_q;
	logic [LCW-1:0]  p_q;
	logic [LCW-1:0]  lat_q;
	logic [LCW-1:0]  lj_q;
	logic            rsp_valid_q;
	rsp_t            rsp_q;

	// Memory ports.
	logic            tkey_we, tord_we, trow_we, eram_we, dram_we;
	logic [IW-1:0]   tkey_waddr, tkey_raddr, trow_waddr, trow_raddr;
	logic [63:0]     tkey_wdata, tkey_rdata;
	logic [IW-1:0]   tord_wdata, tord_rdata;
	row_t            trow_wdata, trow_rdata;
	logic [EAW-1:0]  eram_waddr, eram_raddr;
	logic [95:0]     eram_wdata, eram_rdata;
	logic [DAW-1:0]  dram_waddr, dram_raddr;
	logic [63:0]     dram_wdata, dram_rdata;

	logic            sel_eq;
	logic [LCW-1:0]  n_sel;
	logic [LCW-1:0]  slots_sel;
	logic [LCW-1:0]  lpos;
	logic [63:0]     lkey_rd;
	logic [63:0]     origin_new;
	row_t            row_mod;

	skr_ram #(.DEPTH(TABLE_DEPTH), .WIDTH(64)) u_tkey (
		.clk(clk), .we(tkey_we), .waddr(tkey_waddr), .wdata(tkey_wdata),
		.raddr(tkey_raddr), .rdata(tkey_rdata)
	);
	skr_ram #(.DEPTH(TABLE_DEPTH), .WIDTH(IW)) u_tord (
		.clk(clk), .we(tord_we), .waddr(tkey_waddr), .wdata(tord_wdata),
		.raddr(tkey_raddr), .rdata(tord_rdata)
	);
	skr_ram #(.DEPTH(TABLE_DEPTH), .WIDTH($bits(row_t))) u_trow (
		.clk(clk), .we(trow_we), .waddr(trow_waddr), .wdata(trow_wdata),
		.raddr(trow_raddr), .rdata(trow_rdata)
	);
	skr_ram #(.DEPTH(EDEPTH), .WIDTH(96)) u_eram (
		.clk(clk), .we(eram_we), .waddr(eram_waddr), .wdata(eram_wdata),
		.raddr(eram_raddr), .rdata(eram_rdata)
	);
	skr_ram #(.DEPTH(DDEPTH), .WIDTH(64)) u_dram (
		.clk(clk), .we(dram_we), .waddr(dram_waddr), .wdata(dram_wdata),
		.raddr(dram_raddr), .rdata(dram_rdata)
	);

	// List selection and the shared list compare operand.
	assign sel_eq = (req_q.action == ACT_ADD_EQUIP);
	assign n_sel = sel_eq ? LCW'(row_q.eq_n) : LCW'(row_q.dep_n);
	assign slots_sel = sel_eq ? LCW'(EQUIP_SLOTS) : LCW'(DEPEND_SLOTS);
	assign lkey_rd = sel_eq ? eram_rdata[95:32] : dram_rdata;
	assign origin_new = (req_q.origin_ref != 64'd0) ? req_q.origin_ref : key_q;

	// Row image after a field update.
	always_comb begin
		row_mod = trow_rdata;
		if (req_q.action == ACT_SET_REFS) begin
			row_mod.readiness = req_q.readiness_id;
			row_mod.morale = req_q.morale_id;
		end else if (req_q.action == ACT_SET_STATUS) begin
			row_mod.status = req_q.status_word;
		end
	end

	// Memory address and write control.
	always_comb begin
		tkey_we = 1'b0;
		tord_we = 1'b0;
		trow_we = 1'b0;
		eram_we = 1'b0;
		dram_we = 1'b0;
		tkey_raddr = IW'(idx_q);
		tkey_waddr = IW'(j_q);
		tkey_wdata = tkey_rdata;
		tord_wdata = tord_rdata;
		trow_waddr = slot_q;
		trow_raddr = slot_q;
		trow_wdata = row_q;
		lpos = p_q;
		eram_wdata = eram_rdata;
		dram_wdata = dram_rdata;
		case (state_q)
			S_TSHRD: tkey_raddr = IW'(j_q - CW'(1));
			S_TSHWR: begin
				tkey_we = 1'b1;
				tord_we = 1'b1;
			end
			S_TINS: begin
				tkey_we = 1'b1;
				tord_we = 1'b1;
				trow_we = 1'b1;
				tkey_waddr = IW'(at_q);
				tkey_wdata = key_q;
				tord_wdata = IW'(total_q);
				trow_waddr = IW'(total_q);
				trow_wdata = '{owner: req_q.owner_ref, cohort: req_q.cohort_id,
					origin: origin_new, readiness: 64'd0, morale: 64'd0,
					scope: req_q.scope_code, status: 32'd0, eq_n: '0, dep_n: '0};
			end
			S_ORD: tkey_raddr = IW'(at_q);
			S_LCMP: begin
				if (sel_eq && lkey_rd == req_q.item_key) begin
					eram_we = 1'b1;
					eram_wdata = {eram_rdata[95:32], eram_rdata[31:0] + req_q.item_qty};
				end
			end
			S_LSHRD: lpos = lj_q - LCW'(1);
			S_LSHWR: begin
				lpos = lj_q;
				eram_we = sel_eq;
				dram_we = !sel_eq;
			end
			S_LINS: begin
				lpos = lat_q;
				eram_we = sel_eq;
				dram_we = !sel_eq;
				eram_wdata = {req_q.item_key, req_q.item_qty};
				dram_wdata = req_q.item_key;
			end
			S_WB: trow_we = 1'b1;
			default: ;
		endcase
		eram_raddr = EAW'(slot_q) * EAW'(EQUIP_SLOTS) + EAW'(lpos);
		dram_raddr = DAW'(slot_q) * DAW'(DEPEND_SLOTS) + DAW'(lpos);
		eram_waddr = eram_raddr;
		dram_waddr = dram_raddr;
	end

	assign req_stall = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	// Sequencer, table bookkeeping and response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			total_q <= '0;
			counter_q <= 64'd1;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cfg_valid) begin
						counter_q <= (cfg_data != 64'd0) ? cfg_data : 64'd1;
					end
					if (req_valid) begin
						req_q <= req;
						key_q <= req.entry_key;
						state_q <= S_START;
					end
				end
				S_START: begin
					have_row_q <= 1'b0;
					idx_q <= '0;
					if (req_q.action == ACT_REGISTER && total_q >= CW'(TABLE_DEPTH)) begin
						rc_q <= RC_FULL;
						state_q <= S_DONE;
					end else if (req_q.action > ACT_LOOKUP ||
						(req_q.action == ACT_ADD_EQUIP &&
						(req_q.item_key == 64'd0 || req_q.item_qty == 32'd0)) ||
						(req_q.action == ACT_ADD_DEPEND && req_q.item_key == 64'd0)) begin
						rc_q <= RC_BADARG;
						state_q <= S_DONE;
					end else begin
						rc_q <= RC_OK;
						state_q <= S_SRD;
						if (req_q.action == ACT_REGISTER && key_q == 64'd0) begin
							key_q <= (counter_q == 64'd0) ? 64'd1 : counter_q;
							counter_q <= counter_q + ((counter_q == 64'd0) ? 64'd2 : 64'd1);
						end
					end
				end
				// Linear ordered search of the table.
				S_SRD: begin
					if (idx_q == total_q) begin
						hit_q <= 1'b0;
						at_q <= idx_q;
						state_q <= S_FOUND;
					end else begin
						state_q <= S_SCMP;
					end
				end
				S_SCMP: begin
					if (tkey_rdata == key_q) begin
						hit_q <= 1'b1;
						at_q <= idx_q;
						state_q <= S_FOUND;
					end else if (tkey_rdata > key_q) begin
						hit_q <= 1'b0;
						at_q <= idx_q;
						state_q <= S_FOUND;
					end else begin
						idx_q <= idx_q + CW'(1);
						state_q <= S_SRD;
					end
				end
				S_FOUND: begin
					j_q <= total_q;
					if (req_q.action == ACT_REGISTER) begin
						if (hit_q) begin
							rc_q <= RC_DUP;
							state_q <= S_DONE;
						end else begin
							state_q <= S_TSHRD;
						end
					end else if (!hit_q) begin
						rc_q <= RC_NOTFOUND;
						state_q <= S_DONE;
					end else begin
						state_q <= S_ORD;
					end
				end
				// Open a gap in the sorted key and order arrays.
				S_TSHRD: begin
					state_q <= (j_q == at_q) ? S_TINS : S_TSHWR;
				end
				S_TSHWR: begin
					j_q <= j_q - CW'(1);
					state_q <= S_TSHRD;
				end
				S_TINS: begin
					total_q <= total_q + CW'(1);
					row_q <= trow_wdata;
					have_row_q <= 1'b1;
					state_q <= S_DONE;
				end
				// Fetch the physical slot and the row contents.
				S_ORD: state_q <= S_ORDW;
				S_ORDW: begin
					slot_q <= tord_rdata;
					state_q <= S_ROWR;
				end
				S_ROWR: state_q <= S_ROWW;
				S_ROWW: begin
					row_q <= row_mod;
					have_row_q <= 1'b1;
					p_q <= '0;
					case (req_q.action)
						ACT_SET_REFS, ACT_SET_STATUS: state_q <= S_WB;
						ACT_ADD_EQUIP, ACT_ADD_DEPEND: state_q <= S_LRD;
						default: state_q <= S_DONE;
					endcase
				end
				// Ordered search of the selected sublist.
				S_LRD: begin
					if (p_q == n_sel) begin
						lat_q <= p_q;
						state_q <= S_LFND;
					end else begin
						state_q <= S_LCMP;
					end
				end
				S_LCMP: begin
					if (lkey_rd == req_q.item_key) begin
						state_q <= S_DONE;
					end else if (lkey_rd > req_q.item_key) begin
						lat_q <= p_q;
						state_q <= S_LFND;
					end else begin
						p_q <= p_q + LCW'(1);
						state_q <= S_LRD;
					end
				end
				S_LFND: begin
					lj_q <= n_sel;
					if (n_sel >= slots_sel) begin
						rc_q <= RC_LISTFULL;
						state_q <= S_DONE;
					end else begin
						state_q <= S_LSHRD;
					end
				end
				S_LSHRD: begin
					state_q <= (lj_q == lat_q) ? S_LINS : S_LSHWR;
				end
				S_LSHWR: begin
					lj_q <= lj_q - LCW'(1);
					state_q <= S_LSHRD;
				end
				S_LINS: begin
					if (sel_eq) begin
						row_q.eq_n <= row_q.eq_n + ECW'(1);
					end else begin
						row_q.dep_n <= row_q.dep_n + DCW'(1);
					end
					state_q <= S_WB;
				end
				S_WB: state_q <= S_DONE;
				// Hand the result to the response register once it is free.
				S_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q <= 1'b1;
						rsp_q.result_code <= rc_q;
						rsp_q.entry_id <= key_q;
						if (have_row_q) begin
							rsp_q.entry_owner <= row_q.owner;
							rsp_q.entry_scope <= row_q.scope;
							rsp_q.entry_cohort <= row_q.cohort;
							rsp_q.entry_origin <= row_q.origin;
							rsp_q.entry_readiness <= row_q.readiness;
							rsp_q.entry_morale <= row_q.morale;
							rsp_q.entry_status <= row_q.status;
							rsp_q.equip_count <= 4'(row_q.eq_n);
							rsp_q.depend_count <= 4'(row_q.dep_n);
						end else begin
							rsp_q.entry_owner <= '0;
							rsp_q.entry_scope <= '0;
							rsp_q.entry_cohort <= '0;
							rsp_q.entry_origin <= '0;
							rsp_q.entry_readiness <= '0;
							rsp_q.entry_morale <= '0;
							rsp_q.entry_status <= '0;
							rsp_q.equip_count <= '0;
							rsp_q.depend_count <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- tb/registry_checker.sv -----
// Checker for the sorted key registry: watches the request, response and
// configuration channels, predicts each response and compares it.
// Depends on skr_pkg.
module registry_checker
	import skr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_stall,
	input  req_t        req,
	input  logic        rsp_valid,
	input  logic        rsp_stall,
	input  rsp_t        rsp,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [63:0] cfg_data,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ROWS = 64;
	localparam int SLOTS = 8;

	// Predicted contents of the registry.
	logic [63:0] tbl_key [ROWS];
	logic [63:0] tbl_owner [ROWS];
	logic [63:0] tbl_cohort [ROWS];
	logic [63:0] tbl_origin [ROWS];
	logic [63:0] tbl_ready [ROWS];
	logic [63:0] tbl_morale [ROWS];
	logic [31:0] tbl_scope [ROWS];
	logic [31:0] tbl_status [ROWS];
	logic [63:0] eq_key [ROWS][SLOTS];
	logic [31:0] eq_qty [ROWS][SLOTS];
	logic [63:0] dep_key [ROWS][SLOTS];
	int          eq_n [ROWS];
	int          dep_n [ROWS];
	int          row_total;
	logic [63:0] auto_ctr;

	rsp_t expected_replies [$];

	// First row whose key is at least k; hit tells whether it matches.
	function automatic int locate_row(input logic [63:0] k, output bit hit);
		int i;
		hit = 0;
		for (i = 0; i < row_total; i++) begin
			if (tbl_key[i] == k) begin
				hit = 1;
				return i;
			end
			if (tbl_key[i] > k)
				return i;
		end
		return i;
	endfunction

	// Apply one request to the predicted registry and build its response.
	function automatic rsp_t registry_apply(input req_t q);
		rsp_t r;
		logic [63:0] k;
		int idx, i, at, n;
		bit hit, done, have_row;
		r = '0;
		k = q.entry_key;
		have_row = 0;
		idx = 0;
		r.result_code = RC_OK;
		if (q.action == ACT_REGISTER) begin
			if (row_total >= ROWS) begin
				r.result_code = RC_FULL;
			end else begin
				if (k == 0) begin
					k = auto_ctr;
					auto_ctr = auto_ctr + 1;
					if (k == 0) begin
						k = auto_ctr;
						auto_ctr = auto_ctr + 1;
					end
				end
				idx = locate_row(k, hit);
				if (hit) begin
					r.result_code = RC_DUP;
				end else begin
					for (i = row_total; i > idx; i--) begin
						tbl_key[i] = tbl_key[i-1];
						tbl_owner[i] = tbl_owner[i-1];
						tbl_cohort[i] = tbl_cohort[i-1];
						tbl_origin[i] = tbl_origin[i-1];
						tbl_ready[i] = tbl_ready[i-1];
						tbl_morale[i] = tbl_morale[i-1];
						tbl_scope[i] = tbl_scope[i-1];
						tbl_status[i] = tbl_status[i-1];
						eq_key[i] = eq_key[i-1];
						eq_qty[i] = eq_qty[i-1];
						dep_key[i] = dep_key[i-1];
						eq_n[i] = eq_n[i-1];
						dep_n[i] = dep_n[i-1];
					end
					tbl_key[idx] = k;
					tbl_owner[idx] = q.owner_ref;
					tbl_scope[idx] = q.scope_code;
					tbl_cohort[idx] = q.cohort_id;
					tbl_origin[idx] = (q.origin_ref != 0) ? q.origin_ref : k;
					tbl_ready[idx] = '0;
					tbl_morale[idx] = '0;
					tbl_status[idx] = '0;
					eq_n[idx] = 0;
					dep_n[idx] = 0;
					row_total++;
					have_row = 1;
				end
			end
		end else if (q.action <= ACT_LOOKUP) begin
			if ((q.action == ACT_ADD_EQUIP && (q.item_key == 0 || q.item_qty == 0)) ||
					(q.action == ACT_ADD_DEPEND && q.item_key == 0)) begin
				r.result_code = RC_BADARG;
			end else begin
				idx = locate_row(k, hit);
				if (!hit) begin
					r.result_code = RC_NOTFOUND;
				end else begin
					have_row = 1;
					case (q.action)
						ACT_ADD_EQUIP: begin
							n = eq_n[idx];
							done = 0;
							for (i = 0; i < n; i++) begin
								if (eq_key[idx][i] == q.item_key) begin
									eq_qty[idx][i] = eq_qty[idx][i] + q.item_qty;
									done = 1;
									break;
								end
								if (eq_key[idx][i] > q.item_key)
									break;
							end
							if (!done) begin
								if (n >= SLOTS) begin
									r.result_code = RC_LISTFULL;
								end else begin
									at = i;
									for (i = n; i > at; i--) begin
										eq_key[idx][i] = eq_key[idx][i-1];
										eq_qty[idx][i] = eq_qty[idx][i-1];
									end
									eq_key[idx][at] = q.item_key;
									eq_qty[idx][at] = q.item_qty;
									eq_n[idx] = n + 1;
								end
							end
						end
						ACT_ADD_DEPEND: begin
							n = dep_n[idx];
							done = 0;
							for (i = 0; i < n; i++) begin
								if (dep_key[idx][i] == q.item_key) begin
									done = 1;
									break;
								end
								if (dep_key[idx][i] > q.item_key)
									break;
							end
							if (!done) begin
								if (n >= SLOTS) begin
									r.result_code = RC_LISTFULL;
								end else begin
									at = i;
									for (i = n; i > at; i--)
										dep_key[idx][i] = dep_key[idx][i-1];
									dep_key[idx][at] = q.item_key;
									dep_n[idx] = n + 1;
								end
							end
						end
						ACT_SET_REFS: begin
							tbl_ready[idx] = q.readiness_id;
							tbl_morale[idx] = q.morale_id;
						end
						ACT_SET_STATUS: begin
							tbl_status[idx] = q.status_word;
						end
						default: ;
					endcase
				end
			end
		end else begin
			r.result_code = RC_BADARG;
		end
		r.entry_id = k;
		if (have_row) begin
			r.entry_owner = tbl_owner[idx];
			r.entry_scope = tbl_scope[idx];
			r.entry_cohort = tbl_cohort[idx];
			r.entry_origin = tbl_origin[idx];
			r.entry_readiness = tbl_ready[idx];
			r.entry_morale = tbl_morale[idx];
			r.entry_status = tbl_status[idx];
			r.equip_count = 4'(eq_n[idx]);
			r.depend_count = 4'(dep_n[idx]);
		end
		return r;
	endfunction

	// Report one field that differs from its prediction.
	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: mismatch in %s: expected %h, actual %h", $realtime, name,
				want, got);
			fail_count++;
		end
	endtask

	// Track configuration writes, accepted requests and returned responses.
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			row_total = 0;
			auto_ctr = 64'd1;
			expected_replies.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				auto_ctr = (cfg_data != 0) ? cfg_data : 64'd1;
			if (req_valid && !req_stall)
				expected_replies.push_back(registry_apply(req));
			if (rsp_valid && !rsp_stall) begin
				if (expected_replies.size() == 0) begin
					$display("%0t: response transaction with no request waiting: %h",
						$realtime, rsp);
					fail_count++;
				end else begin
					want = expected_replies.pop_front();
					check_field("result_code", 64'(want.result_code),
						64'(rsp.result_code));
					check_field("entry_id", want.entry_id, rsp.entry_id);
					check_field("entry_owner", want.entry_owner, rsp.entry_owner);
					check_field("entry_scope", 64'(want.entry_scope),
						64'(rsp.entry_scope));
					check_field("entry_cohort", want.entry_cohort, rsp.entry_cohort);
					check_field("entry_origin", want.entry_origin, rsp.entry_origin);
					check_field("entry_readiness", want.entry_readiness,
						rsp.entry_readiness);
					check_field("entry_morale", want.entry_morale, rsp.entry_morale);
					check_field("entry_status", 64'(want.entry_status),
						64'(rsp.entry_status));
					check_field("equip_count", 64'(want.equip_count),
						64'(rsp.equip_count));
					check_field("depend_count", 64'(want.depend_count),
						64'(rsp.depend_count));
				end
			end
			pending = expected_replies.size();
		end
	end

endmodule

// ----- tb/tb_sorted_key_registry_with_sublists.sv -----
// Top of the registry testbench: clock, reset, stimulus and the verdict.
// Depends on skr_pkg, the registry RTL and registry_checker.
module tb_sorted_key_registry_with_sublists;
	import skr_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int  ITEMS_PER_PHASE = 500;
	localparam int  SETTLE_CYCLES = 700;
	localparam longint CYCLE_LIMIT = 20_000_000;
	localparam logic [2:0] ACT_UNDEF_LO = 3'd6;
	localparam logic [2:0] ACT_UNDEF_HI = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	req_t        req = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	rsp_t        rsp;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [63:0] cfg_data = '0;
	int          fail_count;
	int          pending;

	int          idle_pct = 0;
	int          stall_pct = 0;
	longint      cycles = 0;
	logic [63:0] known_keys [$];

	sorted_key_registry_with_sublists dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	registry_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	// Clock with a period of 8 ns.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Receiver stalls at random, and the run is cut off at the cycle limit.
	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < stall_pct);
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Send one request transaction, with random idle cycles ahead of it.
	task automatic send_request(input req_t t);
		while ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req <= t;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
	endtask

	// Load the automatic key counter once the registry has gone quiet.
	task automatic load_first_key(input logic [63:0] v);
		req_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic req_t make_request(input logic [2:0] act, input logic [63:0] k,
			input logic [63:0] item, input logic [31:0] qty);
		req_t t;
		t.action = act;
		t.entry_key = k;
		t.owner_ref = rand64();
		t.scope_code = $urandom;
		t.cohort_id = rand64();
		t.origin_ref = ($urandom_range(4) == 0) ? 64'd0 : rand64();
		t.item_key = item;
		t.item_qty = qty;
		t.readiness_id = rand64();
		t.morale_id = rand64();
		t.status_word = $urandom;
		return t;
	endfunction

	// Entry key biased toward keys that exist, so most actions find a row.
	function automatic logic [63:0] pick_key();
		int roll;
		roll = $urandom_range(99);
		if (roll < 70 && known_keys.size() > 0)
			return known_keys[$urandom_range(known_keys.size() - 1)];
		if (roll < 88)
			return 64'($urandom_range(80));
		return rand64();
	endfunction

	// Random request: mostly list and field updates on live entries.
	function automatic req_t random_request();
		int roll;
		logic [2:0] act;
		logic [63:0] k, item;
		logic [31:0] qty;
		roll = $urandom_range(99);
		if (roll < 5)
			act = ACT_REGISTER;
		else if (roll < 33)
			act = ACT_ADD_EQUIP;
		else if (roll < 58)
			act = ACT_ADD_DEPEND;
		else if (roll < 70)
			act = ACT_SET_REFS;
		else if (roll < 80)
			act = ACT_SET_STATUS;
		else if (roll < 96)
			act = ACT_LOOKUP;
		else
			act = ($urandom_range(1) != 0) ? ACT_UNDEF_HI : ACT_UNDEF_LO;
		if (act == ACT_REGISTER)
			k = ($urandom_range(2) == 0) ? 64'd0 : pick_key();
		else
			k = pick_key();
		roll = $urandom_range(99);
		item = (roll < 4) ? 64'd0 : (roll < 80) ? 64'($urandom_range(1, 12)) : rand64();
		roll = $urandom_range(99);
		qty = (roll < 4) ? 32'd0 : (roll < 15) ? 32'hFFFF_FFF0 + $urandom_range(15)
			: $urandom;
		return make_request(act, k, item, qty);
	endfunction

	// Run one phase of random requests.
	task automatic random_phase(input int n, input int idle, input int stall);
		req_t t;
		idle_pct = idle;
		stall_pct = stall;
		repeat (n) begin
			t = random_request();
			if (t.action == ACT_REGISTER && t.entry_key != 0)
				known_keys.push_back(t.entry_key);
			send_request(t);
		end
	endtask

	initial begin
		req_t t;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, bad arguments and undefined actions.
		send_request(make_request(ACT_LOOKUP, 64'd5, 64'd1, 32'd1));
		send_request(make_request(ACT_ADD_EQUIP, 64'd5, 64'd0, 32'd1));
		send_request(make_request(ACT_ADD_EQUIP, 64'd5, 64'd1, 32'd0));
		send_request(make_request(ACT_ADD_DEPEND, 64'd5, 64'd0, 32'd1));
		send_request(make_request(ACT_UNDEF_LO, 64'd5, 64'd1, 32'd1));
		send_request(make_request(ACT_UNDEF_HI, '1, '1, '1));
		// Automatic key, highest key with provenance defaulted, duplicate, key 5.
		send_request(make_request(ACT_REGISTER, 64'd0, 64'd1, 32'd1));
		t = make_request(ACT_REGISTER, '1, 64'd1, 32'd1);
		t.origin_ref = '0;
		send_request(t);
		send_request(make_request(ACT_REGISTER, 64'd1, 64'd1, 32'd1));
		send_request(make_request(ACT_REGISTER, 64'd5, 64'd1, 32'd1));
		known_keys.push_back('1);
		known_keys.push_back(64'd5);
		// Quantity wraps, then the equipment list fills and overflows.
		send_request(make_request(ACT_ADD_EQUIP, 64'd5, 64'd3, 32'hFFFF_FFFF));
		send_request(make_request(ACT_ADD_EQUIP, 64'd5, 64'd3, 32'd2));
		send_request(make_request(ACT_ADD_EQUIP, 64'd5, '1, 32'd7));
		for (int i = 9; i >= 3; i--)
			send_request(make_request(ACT_ADD_EQUIP, 64'd5, 64'(i * 2), 32'd1));
		// Dependency held twice is ignored; field updates and a lookup on the highest key.
		send_request(make_request(ACT_ADD_DEPEND, 64'd5, 64'd7, 32'd1));
		send_request(make_request(ACT_ADD_DEPEND, 64'd5, 64'd7, 32'd1));
		send_request(make_request(ACT_SET_REFS, '1, 64'd1, 32'd1));
		send_request(make_request(ACT_SET_STATUS, '1, 64'd1, 32'd1));
		send_request(make_request(ACT_LOOKUP, '1, 64'd1, 32'd1));

		// Random phases, with the key counter reloaded between them.
		random_phase(ITEMS_PER_PHASE, 0, 0);
		load_first_key(64'd0);
		random_phase(ITEMS_PER_PHASE, 58, 0);
		load_first_key(64'hFFFF_FFFF_FFFF_FFFE);
		repeat (4)
			send_request(make_request(ACT_REGISTER, 64'd0, 64'd1, 32'd1));
		random_phase(ITEMS_PER_PHASE, 0, 58);
		load_first_key(rand64());
		random_phase(ITEMS_PER_PHASE, 33, 33);

		// Drain outstanding responses, then give the verdict.
		req_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
